### design/btl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types and constants for the bar delimited track lexer: parse
// phases, result kinds, error codes, special bytes and the queue entry.
// ----------------------------------------------------------------------------
package btl_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;

   localparam logic [7:0] BAR_CHAR   = 8'h7C;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;

   localparam logic ERR_CHAR      = 1'b0;
   localparam logic ERR_THIRD_BAR = 1'b1;

   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_OPEN2     = 4'd1,
      PH_OPEN3     = 4'd2,
      PH_BAR       = 4'd3,
      PH_SLASH     = 4'd4,
      PH_COMMENT   = 4'd5,
      PH_AFTER_SEP = 4'd6,
      PH_DONE      = 4'd7,
      PH_ERROR     = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CONTENT   = 3'd0,
      KIND_BAR_END   = 3'd1,
      KIND_TRACK_END = 3'd2,
      KIND_UNCLOSED  = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   // one queue entry: first result of an item and an optional closing result
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  content_byte;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] byte_count;
      logic        error_code;
      logic        has_tail;
      kind_type    tail_kind;
   } entry_type;

endpackage
`default_nettype wire

### design/btl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btl_front
// Parser front end: tracks the parse phase, line and column counters and
// the open bar, and turns each accepted item into at most one queue entry.
// ----------------------------------------------------------------------------
module btl_front #(
   parameter int POSITION_BITS = btl_pkg::POSITION_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  wire  [7:0]           track_byte,
   input  wire                  end_of_track,
   output logic                 enq,
   output btl_pkg::entry_type   enq_entry
);

   localparam int WIDE = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   btl_pkg::phase_type        phase_ff, phase_in, phase_mid;
   logic [POSITION_BITS-1:0]  line_ff, line_in;
   logic [POSITION_BITS-1:0]  col_ff, col_in;
   logic [POSITION_BITS-1:0]  sline_ff, sline_in;
   logic [POSITION_BITS-1:0]  scol_ff, scol_in;
   logic [POSITION_BITS-1:0]  len_ff, len_in;

   logic active, is_bar, is_slash, is_nl, is_cr, do_bar;
   logic p_valid, tail_valid;
   btl_pkg::entry_type ent;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic [15:0] clip16(input logic [POSITION_BITS-1:0] v);
      logic [WIDE-1:0] w;
      w = WIDE'(v);
      return (w > WIDE'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   assign active   = accept && (phase_ff != btl_pkg::PH_DONE)
                     && (phase_ff != btl_pkg::PH_ERROR);
   assign is_bar   = (track_byte == btl_pkg::BAR_CHAR);
   assign is_slash = (track_byte == btl_pkg::SLASH_CHAR);
   assign is_nl    = (track_byte == btl_pkg::LF_CHAR);
   assign is_cr    = (track_byte == btl_pkg::CR_CHAR);

   // next state
   always_comb begin
      phase_mid = phase_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      len_in    = len_ff;
      do_bar    = 1'b0;
      if (active) begin
         col_in  = is_nl ? POS_ONE : sat_inc(col_ff);
         line_in = is_nl ? sat_inc(line_ff) : line_ff;
         unique case (phase_ff)
            btl_pkg::PH_START: begin
               phase_mid = is_bar ? btl_pkg::PH_OPEN2 : btl_pkg::PH_ERROR;
            end
            btl_pkg::PH_OPEN2: begin
               if (is_bar) begin
                  sline_in  = line_in;
                  scol_in   = col_in;
                  phase_mid = btl_pkg::PH_OPEN3;
               end else begin
                  phase_mid = btl_pkg::PH_ERROR;
               end
            end
            btl_pkg::PH_OPEN3: begin
               if (is_bar) phase_mid = btl_pkg::PH_ERROR;
               else do_bar = 1'b1;
            end
            btl_pkg::PH_AFTER_SEP: begin
               if (is_bar) phase_mid = btl_pkg::PH_DONE;
               else do_bar = 1'b1;
            end
            btl_pkg::PH_BAR: do_bar = 1'b1;
            btl_pkg::PH_SLASH: begin
               phase_mid = is_slash ? btl_pkg::PH_COMMENT : btl_pkg::PH_ERROR;
            end
            btl_pkg::PH_COMMENT: begin
               if (is_nl || is_cr) phase_mid = btl_pkg::PH_BAR;
            end
            default: phase_mid = btl_pkg::PH_ERROR;
         endcase
         if (do_bar) begin
            if (is_bar) begin
               len_in    = '0;
               sline_in  = line_in;
               scol_in   = col_in;
               phase_mid = btl_pkg::PH_AFTER_SEP;
            end else if (is_slash) begin
               phase_mid = btl_pkg::PH_SLASH;
            end else begin
               len_in    = sat_inc(len_ff);
               phase_mid = btl_pkg::PH_BAR;
            end
         end
      end
      tail_valid = active && end_of_track && (phase_mid != btl_pkg::PH_DONE)
                   && (phase_mid != btl_pkg::PH_ERROR);
      phase_in = phase_mid;
      if (tail_valid) begin
         phase_in = ((phase_mid == btl_pkg::PH_OPEN2) || (phase_mid == btl_pkg::PH_SLASH))
                    ? btl_pkg::PH_ERROR : btl_pkg::PH_DONE;
      end
   end

   // outputs
   always_comb begin
      ent         = '0;
      ent.kind    = btl_pkg::KIND_CONTENT;
      ent.tail_kind = btl_pkg::KIND_UNCLOSED;
      p_valid     = 1'b0;
      if (active) begin
         if (do_bar) begin
            if (is_bar) begin
               p_valid          = 1'b1;
               ent.kind         = btl_pkg::KIND_BAR_END;
               ent.start_line   = clip16(sline_ff);
               ent.start_column = clip16(scol_ff);
               ent.byte_count   = clip16(len_ff);
            end else if (!is_slash) begin
               p_valid          = 1'b1;
               ent.kind         = btl_pkg::KIND_CONTENT;
               ent.content_byte = track_byte;
            end
         end else if (phase_mid == btl_pkg::PH_ERROR) begin
            p_valid        = 1'b1;
            ent.kind       = btl_pkg::KIND_ERROR;
            ent.error_code = (phase_ff == btl_pkg::PH_OPEN3)
                             ? btl_pkg::ERR_THIRD_BAR : btl_pkg::ERR_CHAR;
         end else if (phase_mid == btl_pkg::PH_DONE) begin
            p_valid  = 1'b1;
            ent.kind = btl_pkg::KIND_TRACK_END;
         end
      end
      if (tail_valid) begin
         ent.tail_kind = (phase_in == btl_pkg::PH_ERROR)
                         ? btl_pkg::KIND_ERROR : btl_pkg::KIND_UNCLOSED;
         if (p_valid) begin
            ent.has_tail = 1'b1;
         end else begin
            ent.kind = ent.tail_kind;
         end
      end
      enq       = p_valid || tail_valid;
      enq_entry = ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= btl_pkg::PH_START;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         sline_ff <= POS_ONE;
         scol_ff  <= POS_ONE;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         len_ff   <= len_in;
      end
   end

endmodule
`default_nettype wire

### design/btl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btl_queue
// Short first-in first-out queue of entries between front and back end.
// ----------------------------------------------------------------------------
module btl_queue #(
   parameter int DEPTH = btl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 enq,
   input  btl_pkg::entry_type  enq_entry,
   output logic                full,
   input  wire                 deq,
   output btl_pkg::entry_type  deq_entry,
   output logic                empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   btl_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_enq, do_deq;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign do_enq    = enq && !full;
   assign do_deq    = deq && !empty;
   assign deq_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      if (do_deq) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      if (do_enq && !do_deq) count_in = count_ff + CW'(1);
      else if (do_deq && !do_enq) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_enq) mem_ff[wr_ptr_ff] <= enq_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### design/btl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btl_back
// Result back end: takes entries from the queue, expands each into one or
// two result items and holds the oldest in an output register.
// ----------------------------------------------------------------------------
module btl_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_empty,
   input  btl_pkg::entry_type  q_entry,
   output logic                q_deq,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic [2:0]          rsp_result_kind,
   output logic [7:0]          rsp_content_byte,
   output logic [15:0]         rsp_bar_start_line,
   output logic [15:0]         rsp_bar_start_column,
   output logic [15:0]         rsp_bar_byte_count,
   output logic                rsp_error_code,
   output logic                rsp_last_of_run
);

   logic               valid_ff, valid_in;
   logic               tail_ff, tail_in;
   btl_pkg::kind_type  tail_kind_ff, tail_kind_in;
   btl_pkg::entry_type out_ff, out_in;
   logic               last_ff, last_in;
   logic               take;

   assign take = !valid_ff || rsp_pop;

   always_comb begin
      valid_in     = valid_ff;
      tail_in      = tail_ff;
      tail_kind_in = tail_kind_ff;
      out_in       = out_ff;
      last_in      = last_ff;
      q_deq        = 1'b0;
      if (take) begin
         if (tail_ff) begin
            out_in      = '0;
            out_in.kind = tail_kind_ff;
            last_in     = 1'b1;
            valid_in    = 1'b1;
            tail_in     = 1'b0;
         end else if (!q_empty) begin
            out_in       = q_entry;
            last_in      = !q_entry.has_tail;
            tail_in      = q_entry.has_tail;
            tail_kind_in = q_entry.tail_kind;
            valid_in     = 1'b1;
            q_deq        = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      last_ff      <= last_in;
      tail_kind_ff <= tail_kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tail_ff  <= tail_in;
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_content_byte     = out_ff.content_byte;
   assign rsp_bar_start_line   = out_ff.start_line;
   assign rsp_bar_start_column = out_ff.start_column;
   assign rsp_bar_byte_count   = out_ff.byte_count;
   assign rsp_error_code       = out_ff.error_code;
   assign rsp_last_of_run      = last_ff;

endmodule
`default_nettype wire

### design/bar_delimited_track_lexer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bar_delimited_track_lexer_unit
// Splits a track of text bytes into bars: streams content bytes, reports
// bar ends with start line, start column and length, and track end/errors.
//
// Input items (track byte, end-of-track flag) are pushed with req_push and
// taken at any edge where req_full is low. Result items are read like a
// queue: while rsp_empty is low the oldest result is on the rsp_ ports and
// rsp_pop takes it. last_of_run marks the final result of one input item.
// Throughput is one item per cycle while req_full is low; an item that
// yields two results (a bar end or content byte closed by the
// end-of-track flag) presents them in turn in the output register. The
// edge that takes an item writes its entry into the entry queue; a later
// edge loads it into the output register. When the receiver stalls, the
// QUEUE_DEPTH entry queue plus the output register absorb items before
// req_full rises.
// Reset returns the parser to expecting the opening bars, sets line and
// column to 1 and drops all pending results. After an error or track end
// further items are taken and ignored until reset.
// ----------------------------------------------------------------------------
module bar_delimited_track_lexer_unit #(
   parameter int POSITION_BITS = btl_pkg::POSITION_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = btl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_push,
   output logic         req_full,
   input  wire  [7:0]   req_track_byte,
   input  wire          req_end_of_track,
   output logic         rsp_empty,
   input  wire          rsp_pop,
   output logic [2:0]   rsp_result_kind,
   output logic [7:0]   rsp_content_byte,
   output logic [15:0]  rsp_bar_start_line,
   output logic [15:0]  rsp_bar_start_column,
   output logic [15:0]  rsp_bar_byte_count,
   output logic         rsp_error_code,
   output logic         rsp_last_of_run
);

   logic               accept;
   logic               enq, q_full, q_empty, q_deq;
   btl_pkg::entry_type enq_entry, deq_entry;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   btl_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .track_byte   (req_track_byte),
      .end_of_track (req_end_of_track),
      .enq          (enq),
      .enq_entry    (enq_entry)
   );

   btl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .enq_entry (enq_entry),
      .full      (q_full),
      .deq       (q_deq),
      .deq_entry (deq_entry),
      .empty     (q_empty)
   );

   btl_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_entry              (deq_entry),
      .q_deq                (q_deq),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_content_byte     (rsp_content_byte),
      .rsp_bar_start_line   (rsp_bar_start_line),
      .rsp_bar_start_column (rsp_bar_start_column),
      .rsp_bar_byte_count   (rsp_bar_byte_count),
      .rsp_error_code       (rsp_error_code),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule
`default_nettype wire
